FILE: rtl/hfcr_pkg.sv
// Package for the header framed command receiver.
// Item kinds, fetch status codes, parser phases, configuration indexes, frame constants and the step decode.
// No dependencies.
package hfcr_pkg;

	// Kind of one input word
	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_LINE_ERR = 2'd1,
		KIND_FETCH    = 2'd2
	} kind_t;

	// Fetch outcome reported with every result word
	typedef enum logic [1:0] {
		FETCH_OK    = 2'd0,
		FETCH_EMPTY = 2'd1,
		FETCH_NONE  = 2'd2
	} fetch_status_t;

	// Frame parser phase
	typedef enum logic [1:0] {
		PH_HDR1 = 2'd0,
		PH_HDR2 = 2'd1,
		PH_CMD  = 2'd2
	} phase_t;

	// Configuration register indexes
	localparam logic CFG_CMD_LOW  = 1'b0;
	localparam logic CFG_CMD_HIGH = 1'b1;

	localparam logic [7:0] HEADER_BYTE   = 8'h55;
	localparam logic [7:0] CMD_LOW_RST   = 8'd1;
	localparam logic [7:0] CMD_HIGH_RST  = 8'd8;

	// Per-item decode of the stage 1 word
	typedef struct packed {
		logic accepted;
		logic push_try;
		logic bad_cmd;
		logic line_err;
		logic pop;
		fetch_status_t status;
	} step_ctl_t;

endpackage

FILE: rtl/hfcr_if.sv
// Handshake channel interfaces of the header framed command receiver.
// Does not reference hfcr_pkg; field widths are kept in line with it.

// Input channel: one received byte, line error or fetch request per word
interface hfcr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel: one word per input word
interface hfcr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  fetch_status;
	logic [7:0]  fetched_command;
	logic        frame_accepted;
	logic [2:0]  queued_count;
	logic [1:0]  parse_phase;
	logic [31:0] valid_frame_count;
	logic [31:0] invalid_command_count;
	logic [31:0] overflow_count;
	logic [31:0] line_error_count;

	modport source (
		output valid, output fetch_status, output fetched_command,
		output frame_accepted, output queued_count, output parse_phase,
		output valid_frame_count, output invalid_command_count,
		output overflow_count, output line_error_count, input ready
	);
	modport sink (
		input valid, input fetch_status, input fetched_command,
		input frame_accepted, input queued_count, input parse_phase,
		input valid_frame_count, input invalid_command_count,
		input overflow_count, input line_error_count, output ready
	);
endinterface

FILE: rtl/header_framed_command_receiver.sv
// Top level of the header framed command receiver: frame parser, command ring
// and event counters. Depends on hfcr_pkg and the channels in hfcr_if.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  item     | in  | valid/ready   | kind, data_byte
//  result   | out | valid/ready   | fetch status and command, frame flag,
//           |     |               | ring fill, phase, four 32 bit counters
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (command_low/high)
//
// Each word is registered into stage 1, decoded and applied to the parser,
// ring and counters, and its result word lands in the output register; one
// word per cycle sustained while the result channel takes its words.
// Stage 1 advances when the output register is empty or being taken, so a
// stalled result holds only one word in stage 1 behind it.
// Reset clears the parser, ring pointers, fill count, counters and the
// command range to 1..8; ring contents are not cleared.
module header_framed_command_receiver #(
	parameter int RING_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	hfcr_in_if.sink      item,
	hfcr_out_if.source   result
);

	localparam int PW    = $clog2(RING_DEPTH);
	localparam int CNT_W = ($clog2(RING_DEPTH) + 1 > 3) ? $clog2(RING_DEPTH) + 1 : 3;

	// Configuration
	logic [7:0] cmd_low_q, cmd_high_q;

	// Stage 1 word
	logic                 valid_s1;
	hfcr_pkg::kind_t      kind_s1;
	logic [7:0]           byte_s1;

	// Parser, ring and counter state
	hfcr_pkg::phase_t     phase_q, phase_d;
	logic [7:0]           ring_q [RING_DEPTH];
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     occ_q;
	logic [31:0]          good_q, bad_q, drop_q, lerr_q;

	// Result register
	logic                   out_valid_q;
	hfcr_pkg::fetch_status_t status_q;
	logic [7:0]             fetched_q;
	logic                   accepted_q;

	hfcr_pkg::step_ctl_t ctl;
	logic adv, in_range, is_hdr, full, empty, push, drop;

	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_low_q  <= hfcr_pkg::CMD_LOW_RST;
			cmd_high_q <= hfcr_pkg::CMD_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hfcr_pkg::CFG_CMD_LOW:  cmd_low_q  <= cfg_data;
				hfcr_pkg::CFG_CMD_HIGH: cmd_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= hfcr_pkg::kind_t'(item.kind);
			byte_s1 <= item.data_byte;
		end
	end

	assign in_range = (byte_s1 >= cmd_low_q) && (byte_s1 <= cmd_high_q);
	assign is_hdr   = (byte_s1 == hfcr_pkg::HEADER_BYTE);
	assign full     = (occ_q == CNT_W'(RING_DEPTH - 1));
	assign empty    = (occ_q == '0);

	// Parser next phase
	always_comb begin
		phase_d = phase_q;
		case (kind_s1)
			hfcr_pkg::KIND_BYTE: begin
				case (phase_q)
					hfcr_pkg::PH_HDR1: if (is_hdr) phase_d = hfcr_pkg::PH_HDR2;
					hfcr_pkg::PH_HDR2: phase_d = is_hdr ? hfcr_pkg::PH_CMD : hfcr_pkg::PH_HDR1;
					hfcr_pkg::PH_CMD:  if (in_range || !is_hdr) phase_d = hfcr_pkg::PH_HDR1;
					default:           phase_d = hfcr_pkg::PH_HDR1;
				endcase
			end
			hfcr_pkg::KIND_LINE_ERR: phase_d = hfcr_pkg::PH_HDR1;
			default: ;
		endcase
	end

	// Step decode
	always_comb begin
		ctl = '0;
		ctl.status = hfcr_pkg::FETCH_NONE;
		case (kind_s1)
			hfcr_pkg::KIND_BYTE: begin
				if (phase_q == hfcr_pkg::PH_CMD) begin
					ctl.accepted = in_range;
					ctl.push_try = in_range;
					ctl.bad_cmd  = !in_range;
				end
			end
			hfcr_pkg::KIND_LINE_ERR: ctl.line_err = 1'b1;
			hfcr_pkg::KIND_FETCH: begin
				ctl.pop    = !empty;
				ctl.status = empty ? hfcr_pkg::FETCH_EMPTY : hfcr_pkg::FETCH_OK;
			end
			default: ;
		endcase
	end

	assign push = ctl.push_try && !full;
	assign drop = ctl.push_try && full;

	// Parser, pointers, fill and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hfcr_pkg::PH_HDR1;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			good_q   <= '0;
			bad_q    <= '0;
			drop_q   <= '0;
			lerr_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (ctl.pop)
				rd_ptr_q <= (rd_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push)
				occ_q <= occ_q + 1'b1;
			else if (ctl.pop)
				occ_q <= occ_q - 1'b1;
			if (ctl.accepted) good_q <= good_q + 32'd1;
			if (ctl.bad_cmd)  bad_q  <= bad_q + 32'd1;
			if (drop)         drop_q <= drop_q + 32'd1;
			if (ctl.line_err) lerr_q <= lerr_q + 32'd1;
		end
	end

	// Command ring write port
	always_ff @(posedge clk) begin
		if (adv && push)
			ring_q[wr_ptr_q] <= byte_s1;
	end

	// Result register, ring read lands here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q   <= ctl.status;
			accepted_q <= ctl.accepted;
			fetched_q  <= ctl.pop ? ring_q[rd_ptr_q] : 8'd0;
		end
	end

	// State registers change only with a new result word, so they read out directly
	assign result.valid                 = out_valid_q;
	assign result.fetch_status          = status_q;
	assign result.fetched_command       = fetched_q;
	assign result.frame_accepted        = accepted_q;
	assign result.queued_count          = occ_q[2:0];
	assign result.parse_phase           = phase_q;
	assign result.valid_frame_count     = good_q;
	assign result.invalid_command_count = bad_q;
	assign result.overflow_count        = drop_q;
	assign result.line_error_count      = lerr_q;

	// Ring never fills its spare slot
	a_occ_limit: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(RING_DEPTH - 1))
		else $error("ring fill beyond depth minus one");

	// A completed frame never comes with a fetch outcome
	a_frame_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && accepted_q |-> status_q == hfcr_pkg::FETCH_NONE)
		else $error("frame flag together with fetch status");

	// A pop drops the fill by one
	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl.pop |=> occ_q == $past(occ_q) - 1'b1)
		else $error("fill count wrong after pop");

	// A stalled result word holds its fetch outcome
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(status_q) && $stable(good_q))
		else $error("stalled result word changed");

endmodule

FILE: bench/header_framed_command_receiver_tb.sv
`timescale 1ns / 1ps
// Testbench of header_framed_command_receiver: feeds bytes, line errors and fetches,
// and checks every result word against a scoreboard model of parser, ring and counters.
// Depends on hfcr_pkg and the channel interfaces in hfcr_if.
module header_framed_command_receiver_tb;

	localparam int RING_SLOTS = 8;
	localparam int IDLE_LIMIT = 1000;
	localparam int LONG_HOLD = 150;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// One result word, kept as plain vectors so that X and Z show up in compares
	typedef struct {
		logic [1:0]  status;
		logic [7:0]  command;
		logic        accepted;
		logic [2:0]  fill;
		logic [1:0]  phase;
		logic [31:0] good;
		logic [31:0] bad;
		logic [31:0] dropped;
		logic [31:0] line_errs;
	} step_word_t;

	// Model of the parser, command ring and counters, with the queue of expected words
	class frame_ring_scoreboard;
		logic [7:0]        cmd_low;
		logic [7:0]        cmd_high;
		hfcr_pkg::phase_t  phase;
		logic [7:0]        slots[RING_SLOTS];
		int                wr_slot;
		int                rd_slot;
		logic [31:0]       good;
		logic [31:0]       bad;
		logic [31:0]       dropped;
		logic [31:0]       line_errs;
		step_word_t        expected_steps[$];
		int                errors;
		int                n_taken;
		int                n_overflow;
		int                n_fetched;
		int                n_empty;

		function new();
			cmd_low = hfcr_pkg::CMD_LOW_RST;
			cmd_high = hfcr_pkg::CMD_HIGH_RST;
			phase = hfcr_pkg::PH_HDR1;
			wr_slot = 0;
			rd_slot = 0;
			good = '0;
			bad = '0;
			dropped = '0;
			line_errs = '0;
			errors = 0;
			n_taken = 0;
			n_overflow = 0;
			n_fetched = 0;
			n_empty = 0;
		endfunction

		function void set_range(logic [7:0] lo, logic [7:0] hi);
			cmd_low = lo;
			cmd_high = hi;
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction

		// Apply one accepted input word and queue the word it must produce
		function void note_item(logic [1:0] kind, logic [7:0] b);
			step_word_t s;
			int nxt;
			s.status = hfcr_pkg::FETCH_NONE;
			s.command = 8'd0;
			s.accepted = 1'b0;
			case (kind)
			hfcr_pkg::KIND_BYTE: begin
				case (phase)
				hfcr_pkg::PH_HDR1: begin
					if (b == hfcr_pkg::HEADER_BYTE)
						phase = hfcr_pkg::PH_HDR2;
				end
				hfcr_pkg::PH_HDR2: begin
					phase = (b == hfcr_pkg::HEADER_BYTE) ? hfcr_pkg::PH_CMD
						: hfcr_pkg::PH_HDR1;
				end
				hfcr_pkg::PH_CMD: begin
					if (b >= cmd_low && b <= cmd_high) begin
						nxt = (wr_slot + 1) % RING_SLOTS;
						if (nxt == rd_slot) begin
							// ring full: frame still counts, command is lost
							dropped = dropped + 1;
							n_overflow++;
						end else begin
							slots[wr_slot] = b;
							wr_slot = nxt;
						end
						good = good + 1;
						s.accepted = 1'b1;
						n_taken++;
						phase = hfcr_pkg::PH_HDR1;
					end else begin
						bad = bad + 1;
						// a further header byte keeps waiting for the command
						if (b != hfcr_pkg::HEADER_BYTE)
							phase = hfcr_pkg::PH_HDR1;
					end
				end
				default: begin
					phase = hfcr_pkg::PH_HDR1;
				end
				endcase
			end
			hfcr_pkg::KIND_LINE_ERR: begin
				line_errs = line_errs + 1;
				phase = hfcr_pkg::PH_HDR1;
			end
			hfcr_pkg::KIND_FETCH: begin
				if (rd_slot == wr_slot) begin
					s.status = hfcr_pkg::FETCH_EMPTY;
					n_empty++;
				end else begin
					s.status = hfcr_pkg::FETCH_OK;
					s.command = slots[rd_slot];
					rd_slot = (rd_slot + 1) % RING_SLOTS;
					n_fetched++;
				end
			end
			default: ;
			endcase
			s.fill = 3'((wr_slot - rd_slot + RING_SLOTS) % RING_SLOTS);
			s.phase = phase;
			s.good = good;
			s.bad = bad;
			s.dropped = dropped;
			s.line_errs = line_errs;
			expected_steps.push_back(s);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
				errors++;
			end
		endfunction

		// Check one accepted result word against the oldest expectation
		function void check_result(step_word_t got);
			step_word_t want;
			if (expected_steps.size() == 0) begin
				$display("%0t: result word with none expected, expected nothing, %s %0h",
					$time, "actual phase", got.phase);
				errors++;
				return;
			end
			want = expected_steps.pop_front();
			compare("fetch_status", want.status, got.status);
			compare("fetched_command", want.command, got.command);
			compare("frame_accepted", want.accepted, got.accepted);
			compare("queued_count", want.fill, got.fill);
			compare("parse_phase", want.phase, got.phase);
			compare("valid_frame_count", want.good, got.good);
			compare("invalid_command_count", want.bad, got.bad);
			compare("overflow_count", want.dropped, got.dropped);
			compare("line_error_count", want.line_errs, got.line_errs);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	bit         idle_on;
	bit         hold_req;
	int         idle_cycles;
	int         items_sent;
	int         settings_used;
	frame_ring_scoreboard sb;

	hfcr_in_if  in_ch();
	hfcr_out_if out_ch();

	header_framed_command_receiver #(
		.RING_DEPTH(RING_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(in_ch),
		.result(out_ch)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result monitor
	always @(posedge clk) begin
		step_word_t got;
		if (arst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
			got.status = out_ch.fetch_status;
			got.command = out_ch.fetched_command;
			got.accepted = out_ch.frame_accepted;
			got.fill = out_ch.queued_count;
			got.phase = out_ch.parse_phase;
			got.good = out_ch.valid_frame_count;
			got.bad = out_ch.invalid_command_count;
			got.dropped = out_ch.overflow_count;
			got.line_errs = out_ch.line_error_count;
			sb.check_result(got);
		end
	end

	// Receiver: random stall bursts, and one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
		end
		$display("header_framed_command_receiver_tb failed");
		$finish;
	end

	// Offer one word, with an optional idle burst first, and wait until it is taken
	task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.data_byte <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_item(kind, b);
		if (kind != KIND_SPARE)
			items_sent++;
	endtask

	task automatic send_frame(input logic [7:0] cmd);
		send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
		send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
		send_item(hfcr_pkg::KIND_BYTE, cmd);
	endtask

	// Stop offering and wait until every expected word is back
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both range registers; the block must be idle
	task automatic set_range(input logic [7:0] lo, input logic [7:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= hfcr_pkg::CFG_CMD_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= hfcr_pkg::CFG_CMD_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_range(lo, hi);
		settings_used++;
	endtask

	// Mostly well-formed frames with random commands, plus fetches, errors and noise
	task automatic run_random(input int n, input int fetch_pct);
		int start;
		int pick;
		logic [7:0] cmd;
		start = items_sent;
		while (items_sent - start < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
				case ($urandom_range(0, 9))
				0: begin
					// broken second header
					send_item(hfcr_pkg::KIND_BYTE, 8'($urandom()));
				end
				1: begin
					send_item(hfcr_pkg::KIND_LINE_ERR, 8'($urandom()));
				end
				default: begin
					send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
					if ($urandom_range(0, 7) == 0)
						send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
					if (sb.cmd_low <= sb.cmd_high && $urandom_range(0, 3) != 0)
						cmd = 8'(sb.cmd_low
							+ $urandom_range(0, sb.cmd_high - sb.cmd_low));
					else
						cmd = 8'($urandom());
					send_item(hfcr_pkg::KIND_BYTE, cmd);
				end
				endcase
			end else if (pick < 60 + fetch_pct) begin
				send_item(hfcr_pkg::KIND_FETCH, 8'($urandom()));
			end else if (pick < 64 + fetch_pct) begin
				send_item(hfcr_pkg::KIND_LINE_ERR, 8'($urandom()));
			end else if (pick < 66 + fetch_pct) begin
				send_item(KIND_SPARE, 8'($urandom()));
			end else begin
				send_item(hfcr_pkg::KIND_BYTE, 8'($urandom()));
			end
		end
	endtask

	// Main sequence
	initial begin
		logic [7:0] lo;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hfcr_pkg::CFG_CMD_LOW;
		cfg_data = 8'd0;
		in_ch.valid = 1'b0;
		in_ch.kind = hfcr_pkg::KIND_BYTE;
		in_ch.data_byte = 8'd0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		items_sent = 0;
		settings_used = 1;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty fetch, spare kind, range edges, repeated header, errors
		send_item(hfcr_pkg::KIND_FETCH, 8'h00);
		send_item(KIND_SPARE, 8'hFF);
		send_item(hfcr_pkg::KIND_LINE_ERR, 8'h00);
		send_frame(8'd1);
		send_frame(8'd8);
		send_frame(8'd0);
		send_frame(hfcr_pkg::HEADER_BYTE);
		send_item(hfcr_pkg::KIND_BYTE, 8'd2);
		send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
		send_item(hfcr_pkg::KIND_BYTE, 8'hFF);
		send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
		send_item(hfcr_pkg::KIND_BYTE, hfcr_pkg::HEADER_BYTE);
		send_item(hfcr_pkg::KIND_LINE_ERR, 8'hFF);
		send_item(hfcr_pkg::KIND_FETCH, 8'hFF);
		send_item(hfcr_pkg::KIND_FETCH, 8'h00);
		send_item(hfcr_pkg::KIND_FETCH, 8'hA5);
		send_item(hfcr_pkg::KIND_FETCH, 8'h5A);

		// Reset range, with a full pause of the sender part way
		run_random(120, 20);
		wait_drained();
		run_random(150, 30);

		// Full range, header byte inside it; receiver holds off to fill the block
		wait_drained();
		set_range(8'd0, 8'd255);
		run_random(60, 8);
		hold_req = 1'b1;
		run_random(200, 8);

		// Empty range, drains the ring
		wait_drained();
		set_range(8'h60, 8'h10);
		run_random(150, 30);

		// Only the header byte is a command
		wait_drained();
		set_range(hfcr_pkg::HEADER_BYTE, hfcr_pkg::HEADER_BYTE);
		run_random(150, 15);

		wait_drained();
		set_range(8'd0, 8'd0);
		run_random(140, 20);

		wait_drained();
		set_range(8'd255, 8'd255);
		run_random(140, 20);

		// Random ranges
		repeat (2) begin
			wait_drained();
			lo = 8'($urandom_range(0, 255));
			set_range(lo, 8'($urandom_range(lo, 255)));
			run_random(150, 18);
		end

		// Last stretch without idling
		wait_drained();
		idle_on = 1'b0;
		set_range(8'd3, 8'd200);
		run_random(200, 15);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d words over %0d range settings: %0d frames taken, %0d %s",
			items_sent, settings_used, sb.n_taken, sb.n_overflow, "lost to a full ring,");
		$display("%0d commands fetched, %0d fetches from an empty ring, %0d bad command bytes.",
			sb.n_fetched, sb.n_empty, sb.bad);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("header_framed_command_receiver_tb passed");
		else
			$display("header_framed_command_receiver_tb failed");
		$finish;
	end

endmodule
